@@ hdl/integer_to_roman_encoder_defines.svh @@
// Assertion macros for the integer to Roman numeral encoder.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH
`define INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define I2R_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under reset.
`define I2R_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define I2R_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define I2R_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/i2r_pkg.sv @@
// Shared types, symbol constants and digit pattern functions for the Roman encoder.
// No dependencies; used by every module of the block.
package i2r_pkg;

   typedef logic [11:0] value_type;
   typedef logic [3:0]  digit_type;
   typedef logic [2:0]  len_type;
   typedef logic [6:0]  ascii_type;
   typedef logic [1:0]  place_type;
   typedef logic [1:0]  char_idx_type;

   localparam value_type ValueMax = 12'd3999;

   localparam ascii_type SymC = 7'd67;
   localparam ascii_type SymD = 7'd68;
   localparam ascii_type SymI = 7'd73;
   localparam ascii_type SymL = 7'd76;
   localparam ascii_type SymM = 7'd77;
   localparam ascii_type SymV = 7'd86;
   localparam ascii_type SymX = 7'd88;

   localparam place_type PlaceThousands = 2'd0;
   localparam place_type PlaceHundreds  = 2'd1;
   localparam place_type PlaceTens      = 2'd2;
   localparam place_type PlaceUnits     = 2'd3;

   // Valid bit, digits, lengths and non-empty mask of one numeral, indexed by place
   typedef struct packed {
      logic                valid;
      digit_type [3:0]     digits;
      len_type   [3:0]     lens;
      logic      [3:0]     mask;
   } digit_bundle_type;

   function automatic len_type digit_len(input digit_type d);
      len_type n;
      case (d) inside
         4'd4, 4'd9:       n = 3'd2;
         [4'd5:4'd8]:      n = 3'(d - 4'd4);
         [4'd1:4'd3]:      n = 3'(d);
         default:          n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic ascii_type one_sym(input place_type p);
      ascii_type s;
      unique case (p)
         PlaceThousands: s = SymM;
         PlaceHundreds:  s = SymC;
         PlaceTens:      s = SymX;
         PlaceUnits:     s = SymI;
         default:        s = SymI;
      endcase
      return s;
   endfunction

   function automatic ascii_type five_sym(input place_type p);
      ascii_type s;
      unique case (p)
         PlaceThousands: s = SymM;
         PlaceHundreds:  s = SymD;
         PlaceTens:      s = SymL;
         PlaceUnits:     s = SymV;
         default:        s = SymV;
      endcase
      return s;
   endfunction

   function automatic ascii_type ten_sym(input place_type p);
      ascii_type s;
      unique case (p)
         PlaceThousands: s = SymM;
         PlaceHundreds:  s = SymM;
         PlaceTens:      s = SymC;
         PlaceUnits:     s = SymX;
         default:        s = SymX;
      endcase
      return s;
   endfunction

   // Character k of the pattern for digit d at place p
   function automatic ascii_type digit_symbol(input place_type p, input digit_type d,
                                              input char_idx_type k);
      ascii_type s;
      if (d == 4'd9) begin
         s = (k == 2'd0) ? one_sym(p) : ten_sym(p);
      end else if (d >= 4'd5) begin
         s = (k == 2'd0) ? five_sym(p) : one_sym(p);
      end else if (d == 4'd4) begin
         s = (k == 2'd0) ? one_sym(p) : five_sym(p);
      end else begin
         s = one_sym(p);
      end
      return s;
   endfunction

   // Lowest set place of a mask; zero when the mask is empty
   function automatic place_type first_place(input logic [3:0] m);
      place_type p;
      p = PlaceThousands;
      for (int i = 3; i >= 0; i--) begin
         if (m[i]) p = 2'(i);
      end
      return p;
   endfunction

endpackage

@@ hdl/i2r_digit_pipe.sv @@
// Four-stage decimal split pipeline: clamp and thousands, hundreds, tens and units, lengths.
// Depends on i2r_pkg.
module i2r_digit_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  i2r_pkg::value_type        in_value,
   output logic                      in_ready,
   input  logic                      out_take,
   output i2r_pkg::digit_bundle_type out_bundle
);
   import i2r_pkg::*;

   logic             s1_adv, s2_adv, s3_adv, s4_adv;

   logic             s1_valid_ff;
   logic [1:0]       s1_th_ff;
   logic [9:0]       s1_rem_ff;
   logic [1:0]       s1_th_in;
   logic [9:0]       s1_rem_in;
   value_type        clamped;
   value_type        rem_wide;

   logic             s2_valid_ff;
   logic [1:0]       s2_th_ff;
   digit_type        s2_hu_ff;
   logic [6:0]       s2_rem_ff;
   digit_type        s2_hu_in;
   logic [9:0]       s2_rem_wide;

   logic             s3_valid_ff;
   digit_type [3:0]  s3_digits_ff;
   digit_type        s3_te_in;
   logic [6:0]       s3_un_wide;

   digit_bundle_type bundle_ff;
   digit_bundle_type bundle_in;

   // A stage moves on when it is empty or its successor moves on
   assign s4_adv   = !bundle_ff.valid || out_take;
   assign s3_adv   = !s3_valid_ff || s4_adv;
   assign s2_adv   = !s2_valid_ff || s3_adv;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   // Stage 1: clamp, thousands
   always_comb begin
      clamped  = (in_value > ValueMax) ? ValueMax : in_value;
      s1_th_in = 2'd0;
      rem_wide = clamped;
      for (int i = 1; i <= 3; i++) begin
         if (clamped >= 12'(i * 1000)) begin
            s1_th_in = 2'(i);
            rem_wide = clamped - 12'(i * 1000);
         end
      end
      s1_rem_in = rem_wide[9:0];
   end

   // Stage 2: hundreds
   always_comb begin
      s2_hu_in    = 4'd0;
      s2_rem_wide = s1_rem_ff;
      for (int i = 1; i <= 9; i++) begin
         if (s1_rem_ff >= 10'(i * 100)) begin
            s2_hu_in    = 4'(i);
            s2_rem_wide = s1_rem_ff - 10'(i * 100);
         end
      end
   end

   // Stage 3: tens and units
   always_comb begin
      s3_te_in   = 4'd0;
      s3_un_wide = s2_rem_ff;
      for (int i = 1; i <= 9; i++) begin
         if (s2_rem_ff >= 7'(i * 10)) begin
            s3_te_in   = 4'(i);
            s3_un_wide = s2_rem_ff - 7'(i * 10);
         end
      end
   end

   // Stage 4: pattern lengths and non-empty mask
   always_comb begin
      bundle_in.valid  = s3_valid_ff;
      bundle_in.digits = s3_digits_ff;
      for (int p = 0; p < 4; p++) begin
         bundle_in.lens[p] = digit_len(s3_digits_ff[p]);
         bundle_in.mask[p] = (s3_digits_ff[p] != 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff     <= in_valid;
         if (s2_adv) s2_valid_ff     <= s1_valid_ff;
         if (s3_adv) s3_valid_ff     <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_th_ff  <= s1_th_in;
         s1_rem_ff <= s1_rem_in;
      end
      if (s2_adv) begin
         s2_th_ff  <= s1_th_ff;
         s2_hu_ff  <= s2_hu_in;
         s2_rem_ff <= s2_rem_wide[6:0];
      end
      if (s3_adv) begin
         s3_digits_ff[PlaceThousands] <= {2'b00, s2_th_ff};
         s3_digits_ff[PlaceHundreds]  <= s2_hu_ff;
         s3_digits_ff[PlaceTens]      <= s3_te_in;
         s3_digits_ff[PlaceUnits]     <= s3_un_wide[3:0];
      end
      // Keep the whole output bundle in one block; only its valid bit is reset
      if (reset) begin
         bundle_ff.valid <= 1'b0;
      end else if (s4_adv) begin
         bundle_ff.valid <= bundle_in.valid;
      end
      if (s4_adv) begin
         bundle_ff.digits <= bundle_in.digits;
         bundle_ff.lens   <= bundle_in.lens;
         bundle_ff.mask   <= bundle_in.mask;
      end
   end

   assign out_bundle = bundle_ff;

endmodule

@@ hdl/i2r_serializer.sv @@
// Character serialiser: walks the non-empty digits of one numeral, one symbol per cycle.
// Depends on i2r_pkg and integer_to_roman_encoder_defines.svh.
`include "integer_to_roman_encoder_defines.svh"
module i2r_serializer (
   input  logic                      clock,
   input  logic                      reset,
   input  i2r_pkg::digit_bundle_type in_bundle,
   output logic                      in_take,
   output logic                      rsp_valid,
   output i2r_pkg::ascii_type        rsp_symbol,
   output logic                      rsp_last
);
   import i2r_pkg::*;

   logic            active_ff;
   place_type       pos_ff;
   char_idx_type    k_ff;
   digit_type [3:0] digits_ff;
   len_type   [3:0] lens_ff;
   logic      [3:0] mask_ff;

   logic            rsp_valid_ff;
   ascii_type       rsp_symbol_ff;
   logic            rsp_last_ff;

   len_type         cur_len;
   len_type         k_ext;
   logic            digit_end;
   logic      [3:0] higher;
   logic            finishing;
   logic            load;

   assign cur_len   = lens_ff[pos_ff];
   assign k_ext     = {1'b0, k_ff};
   assign digit_end = (k_ext == cur_len - 3'd1);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         higher[i] = mask_ff[i] && (2'(i) > pos_ff);
      end
   end

   assign finishing = active_ff && digit_end && (higher == 4'd0);
   // Empty numerals are dropped at once; others wait for the current run to end
   assign in_take   = (in_bundle.mask == 4'd0) || !active_ff || finishing;
   assign load      = in_bundle.valid && (in_bundle.mask != 4'd0) && (!active_ff || finishing);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= active_ff;
         if (load) begin
            active_ff <= 1'b1;
         end else if (finishing) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_symbol_ff <= digit_symbol(pos_ff, digits_ff[pos_ff], k_ff);
      rsp_last_ff   <= finishing;
      if (load) begin
         digits_ff <= in_bundle.digits;
         lens_ff   <= in_bundle.lens;
         mask_ff   <= in_bundle.mask;
         pos_ff    <= first_place(in_bundle.mask);
         k_ff      <= 2'd0;
      end else if (active_ff) begin
         if (digit_end) begin
            pos_ff <= first_place(higher);
            k_ff   <= 2'd0;
         end else begin
            k_ff <= k_ff + 2'd1;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   `I2R_ASSERT_IMPLY(a_k_in_pattern, clock, reset, active_ff, k_ext < cur_len, "char index past digit pattern")
   `I2R_ASSERT_IMPLY(a_pos_nonempty, clock, reset, active_ff, mask_ff[pos_ff], "serialiser on an empty digit")
   `I2R_ASSERT_NEXT(a_run_unbroken, clock, reset, rsp_valid && !rsp_last, rsp_valid, "gap inside a numeral")

endmodule

@@ hdl/integer_to_roman_encoder.sv @@
// Top level of the integer to Roman numeral encoder.
// Depends on i2r_pkg, i2r_digit_pipe and i2r_serializer.
//
// Usage:
//   Input: drive req_value and raise start; the transaction is taken at a rising
//   edge with start high and busy low. Values above 3999 are clamped to 3999.
//   Output: each character of the numeral appears on rsp_symbol (ASCII) for one
//   cycle with rsp_valid high; rsp_last marks the final character. Characters of
//   one numeral come in consecutive cycles, most significant symbol first.
//   A value of zero produces no output at all.
// Path: after the accepting edge a value passes the four pipeline stages
//   (clamp/thousands, hundreds, tens/units and pattern lengths), waits to be loaded
//   into the serialiser, then leaves through the serialiser's output register.
// Throughput: the serialiser emits one character a cycle, and a numeral has
//   1 to 15 characters (15 for 3888). A new transaction can be taken every cycle
//   while the pipeline has room; busy rises only when all four stages are full
//   behind a serialiser still mid-numeral.
// Reset: synchronous, active high; drops every transaction in flight and clears
//   rsp_valid. The receiver cannot stall: results are strobed and never held.
module integer_to_roman_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  i2r_pkg::value_type req_value,
   output logic               rsp_valid,
   output i2r_pkg::ascii_type rsp_symbol,
   output logic               rsp_last
);
   import i2r_pkg::*;

   logic             pipe_ready;
   logic             ser_take;
   digit_bundle_type bundle;

   // Decimal split; advance one stage per cycle, hold on back-pressure
   i2r_digit_pipe u_digit_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start),
      .in_value   (req_value),
      .in_ready   (pipe_ready),
      .out_take   (ser_take),
      .out_bundle (bundle)
   );

   // Character emission; take the next numeral in the cycle the current one ends
   i2r_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .in_bundle  (bundle),
      .in_take    (ser_take),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

   assign busy = !pipe_ready;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for integer_to_roman_encoder: directed, digit-pattern, random and burst tests.
// Depends on i2r_pkg and the RTL of integer_to_roman_encoder; nothing else.
`timescale 1ns / 100ps

module tb_top;
   import i2r_pkg::*;

   // One expected character of a numeral, as it should appear on the result ports
   typedef struct packed {
      ascii_type symbol;
      logic      last;
   } roman_char_type;

   localparam int ClockPeriod   = 12;
   localparam int ResetCycles   = 10;
   localparam int MaxGap        = 18;
   // Quiet cycles allowed before giving up; far beyond any gap plus pipeline latency
   localparam int QuietLimit    = 1000;
   // Margin allowed for the drain once every owed character is out
   localparam int DrainCycles   = 25;
   localparam int RandomCount   = 175;
   localparam int BurstCount    = 30;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   value_type req_value;
   logic      rsp_valid;
   ascii_type rsp_symbol;
   logic      rsp_last;

   roman_char_type expected_chars[$];   // characters still owed by the block, oldest first
   ascii_type      numeral_chars[$];    // scratch for the numeral being predicted
   int             fail_count;
   int             quiet_cycles;
   bit             sender_idles;        // when clear, offer transactions back to back

   integer_to_roman_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Append the symbols of one decimal digit, given its one, five and ten symbols
   function automatic void add_digit_symbols(input int unsigned digit, input ascii_type one,
                                             input ascii_type five, input ascii_type ten);
      int unsigned k;
      if (digit == 9) begin
         numeral_chars.push_back(one);
         numeral_chars.push_back(ten);
      end else if (digit >= 5) begin
         numeral_chars.push_back(five);
         for (k = 5; k < digit; k++) numeral_chars.push_back(one);
      end else if (digit == 4) begin
         numeral_chars.push_back(one);
         numeral_chars.push_back(five);
      end else begin
         for (k = 0; k < digit; k++) numeral_chars.push_back(one);
      end
   endfunction

   // Work out the numeral for one accepted value and queue its characters
   function automatic void predict_numeral(input value_type value);
      int unsigned clamped;
      int unsigned k;
      clamped = 32'((value > ValueMax) ? ValueMax : value);
      numeral_chars = {};
      for (k = 0; k < clamped / 1000; k++) numeral_chars.push_back(SymM);
      add_digit_symbols((clamped / 100) % 10, SymC, SymD, SymM);
      add_digit_symbols((clamped / 10) % 10, SymX, SymL, SymC);
      add_digit_symbols(clamped % 10, SymI, SymV, SymX);
      // A zero value owes nothing: the loop simply queues no characters
      for (k = 0; k < numeral_chars.size(); k++) begin
         expected_chars.push_back('{symbol: numeral_chars[k],
                                    last:   (k == numeral_chars.size() - 1)});
      end
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Offer one value and hold it until the block takes it. Start is left high on
   // return so that a following transaction with no gap is not dropped and
   // raised again within the same step.
   task automatic send_value(input value_type value);
      int gap;
      gap = sender_idles ? $urandom_range(MaxGap, 0) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      // Busy read here is the value before the edge, so the test is race-free
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_numeral(value);
   endtask

   // Draw a value from a mix that favours the legal range but visits the corners
   function automatic value_type draw_value();
      int unsigned pick;
      value_type   value;
      pick = $urandom_range(99, 0);
      if (pick < 65) begin
         value = value_type'($urandom_range(3999, 1));
      end else if (pick < 75) begin
         // Clamped range
         value = value_type'($urandom_range(4095, 4000));
      end else if (pick < 80) begin
         value = '0;
      end else if (pick < 92) begin
         // Long numerals: three thousands and digits of seven or eight
         value = value_type'(3000 + 100 * $urandom_range(8, 7) + 10 * $urandom_range(8, 7)
                             + $urandom_range(8, 7));
      end else begin
         value = value_type'($urandom);
      end
      return value;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, the clamped range, the empty numeral and alternating bit patterns
   task automatic test_value_extremes();
      value_type extremes[$];
      extremes = '{12'd0, 12'd1, 12'd4095, 12'd4000, 12'd3999, 12'd3888, 12'd2730,
                   12'd1365, 12'd2048, 12'd1000, 12'd3000};
      sender_idles = 1'b1;
      foreach (extremes[i]) send_value(extremes[i]);
   endtask

   // Every digit in the hundreds, tens and units places, including the subtractive pairs
   task automatic test_digit_patterns();
      value_type patterns[$];
      patterns = '{12'd111, 12'd222, 12'd333, 12'd444, 12'd555, 12'd666, 12'd777,
                   12'd888, 12'd999, 12'd1994, 12'd49, 12'd90, 12'd500, 12'd1606};
      sender_idles = 1'b0;
      foreach (patterns[i]) send_value(patterns[i]);
   endtask

   // Random values with idling switched on and off in stretches
   task automatic test_random_values();
      int n;
      for (n = 0; n < RandomCount; n++) begin
         if (n % 20 == 0) sender_idles = ($urandom_range(3, 0) != 0);
         send_value(draw_value());
      end
   endtask

   // Long numerals back to back, to fill the pipeline and drive busy high
   task automatic test_busy_burst();
      int n;
      sender_idles = 1'b0;
      for (n = 0; n < BurstCount; n++) begin
         send_value(value_type'(3000 + 100 * $urandom_range(8, 7) + 88));
      end
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   // Compare every strobed character with the oldest one owed
   always @(posedge clock) begin
      roman_char_type owed;
      if (!reset && rsp_valid) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual symbol %0d last %0b",
                     $time, rsp_symbol, rsp_last);
            fail_count++;
         end else begin
            owed = expected_chars.pop_front();
            if (rsp_symbol !== owed.symbol) begin
               $display("%0t: symbol mismatch: expected %0d (%c), actual %0d (%c)",
                        $time, owed.symbol, owed.symbol, rsp_symbol, rsp_symbol);
               fail_count++;
            end
            if (rsp_last !== owed.last) begin
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, owed.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: advance on any accepted transaction or result, otherwise count towards the limit
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no progress for %0d cycles, %0d characters still owed",
                  $time, QuietLimit, expected_chars.size());
         $display("[integer_to_roman_encoder] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_value    = '0;
      fail_count   = 0;
      quiet_cycles = 0;
      sender_idles = 1'b1;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      test_value_extremes();
      test_digit_patterns();
      test_random_values();
      test_busy_burst();

      // Drop start, then wait for every owed character and a margin for strays
      start <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0) begin
         $display("[integer_to_roman_encoder] OK");
      end else begin
         $display("[integer_to_roman_encoder] ERROR");
      end
      $finish;
   end

endmodule
